### rtl/core/mmc3_pkg.sv
`timescale 1ns / 1ps

package mmc3_pkg;

    // Widths fixed by the access and result formats
    localparam int RomAddrBitsDefault = 21;
    localparam int MemAddrW           = 21;
    localparam int CfgAddrW           = 4;
    localparam int CfgDataW           = 32;
    localparam int BankCountW         = 9;

    // Access commands
    localparam logic [2:0] CMD_CPU_READ  = 3'd0;
    localparam logic [2:0] CMD_CPU_WRITE = 3'd1;
    localparam logic [2:0] CMD_CHR_READ  = 3'd2;
    localparam logic [2:0] CMD_CHR_WRITE = 3'd3;
    localparam logic [2:0] CMD_PPU_WATCH = 3'd4;

    // Result targets
    localparam logic [1:0] TGT_NONE    = 2'd0;
    localparam logic [1:0] TGT_PRG_ROM = 2'd1;
    localparam logic [1:0] TGT_PRG_RAM = 2'd2;
    localparam logic [1:0] TGT_CHR     = 2'd3;

    // Configuration register indexes (byte address / 4)
    localparam logic [1:0] REG_PRG_COUNT = 2'd0;
    localparam logic [1:0] REG_CHR_COUNT = 2'd1;
    localparam logic [1:0] REG_CHR_RAM   = 2'd2;

    // Mapper register windows, selected by CPU address bits 14..13
    localparam logic [1:0] WIN_BANK   = 2'd0;
    localparam logic [1:0] WIN_MIRROR = 2'd1;
    localparam logic [1:0] WIN_IRQ    = 2'd2;
    localparam logic [1:0] WIN_IRQ_EN = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  value;
    } item_t;

    typedef struct packed {
        logic [1:0]          target;
        logic [MemAddrW-1:0] mem_addr;
        logic                write_strobe;
        logic                out_of_range;
        logic                irq_line;
        logic                mirror_vertical;
    } result_t;

    typedef struct packed {
        logic [BankCountW-1:0] prg_bank_count;
        logic [BankCountW-1:0] chr_bank_count;
        logic                  chr_is_ram;
    } cfg_t;

    typedef struct packed {
        logic [7:0][7:0] bank_regs;
        logic [2:0]      bank_select;
        logic            prg_swap_mode;
        logic            chr_invert_mode;
        logic            mirror_state;
        logic [7:0]      irq_latch;
        logic [7:0]      irq_count;
        logic            irq_reload_flag;
        logic            irq_enabled;
        logic            irq_pending;
        logic            prev_a12;
    } map_state_t;

    typedef struct packed {
        logic [1:0]          target;
        logic [MemAddrW-1:0] mem_addr;
        logic                write_strobe;
        logic                out_of_range;
    } xlate_t;

endpackage

### rtl/core/mmc3_cfg.sv
`timescale 1ns / 1ps

module mmc3_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mmc3_pkg::CfgAddrW-1:0]    paddr,
    input  logic [mmc3_pkg::CfgDataW-1:0]    pwdata,
    output logic [mmc3_pkg::CfgDataW-1:0]    prdata,
    output logic                             pready,
    output mmc3_pkg::cfg_t                   cfg
);
    import mmc3_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_PRG_COUNT: cfg_next.prg_bank_count = pwdata[BankCountW-1:0];
                REG_CHR_COUNT: cfg_next.chr_bank_count = pwdata[BankCountW-1:0];
                REG_CHR_RAM:   cfg_next.chr_is_ram     = pwdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prg_bank_count <= BankCountW'(2);
            cfg_reg.chr_bank_count <= BankCountW'(8);
            cfg_reg.chr_is_ram     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_PRG_COUNT: prdata = CfgDataW'(cfg_reg.prg_bank_count);
            REG_CHR_COUNT: prdata = CfgDataW'(cfg_reg.chr_bank_count);
            REG_CHR_RAM:   prdata = CfgDataW'(cfg_reg.chr_is_ram);
            default:       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/mmc3_xlate.sv
`timescale 1ns / 1ps

module mmc3_xlate
#(
    parameter int ROM_ADDR_BITS = mmc3_pkg::RomAddrBitsDefault
)
(
    input  mmc3_pkg::item_t      item,
    input  mmc3_pkg::cfg_t       cfg,
    input  mmc3_pkg::map_state_t state,
    output mmc3_pkg::xlate_t     xl
);
    import mmc3_pkg::*;

    localparam int FullW = BankCountW + 13;

    logic [FullW-1:0]      rom_mask;
    logic [BankCountW-1:0] last_bank;
    logic [BankCountW-1:0] second_bank;
    logic [BankCountW-1:0] sel_bank;
    logic [BankCountW-1:0] prg_bank;
    logic [FullW-1:0]      prg_full;
    logic [1:0]            slot;
    logic [12:0]           chr_p;
    logic [7:0]            chr_bank;
    logic [17:0]           chr_abs;
    logic                  chr_oor;
    logic                  is_ram_win;

    // Keep the PRG address bits that the ROM actually decodes
    always_comb
    begin
        for (int i = 0; i < FullW; i++)
        begin
            rom_mask[i] = (i < ROM_ADDR_BITS);
        end
    end

    // PRG window selection and clamp
    always_comb
    begin
        slot        = item.addr[14:13];
        last_bank   = (cfg.prg_bank_count == '0) ? '0 : cfg.prg_bank_count - 1'b1;
        second_bank = (cfg.prg_bank_count < BankCountW'(2)) ? '0
                                                            : cfg.prg_bank_count - 2'd2;
        if (slot == 2'd1)
            sel_bank = BankCountW'(state.bank_regs[7]);
        else if (slot == 2'd3)
            sel_bank = last_bank;
        else if ((slot == 2'd0) == !state.prg_swap_mode)
            sel_bank = BankCountW'(state.bank_regs[6]);
        else
            sel_bank = second_bank;
        prg_bank = (sel_bank >= cfg.prg_bank_count) ? last_bank : sel_bank;
        prg_full = {prg_bank, item.addr[12:0]} & rom_mask;
    end

    // CHR: 2KB windows in the low half, 1KB windows in the high half
    always_comb
    begin
        chr_p     = item.addr[12:0];
        chr_p[12] = item.addr[12] ^ state.chr_invert_mode;
        if (!chr_p[12])
        begin
            chr_bank = state.bank_regs[{2'b00, chr_p[11]}];
            chr_abs  = {chr_bank[7:1], chr_p[10:0]};
        end
        else
        begin
            chr_bank = state.bank_regs[{1'b0, 2'd2} + {1'b0, chr_p[11:10]}];
            chr_abs  = {chr_bank, chr_p[9:0]};
        end
        chr_oor = {1'b0, chr_abs[17:10]} >= cfg.chr_bank_count;
    end

    assign is_ram_win = (item.addr[15:13] == 3'b011);

    always_comb
    begin
        xl = '0;
        case (item.cmd)
            CMD_CPU_READ,
            CMD_CPU_WRITE:
            begin
                if (is_ram_win)
                begin
                    xl.target       = TGT_PRG_RAM;
                    xl.mem_addr     = MemAddrW'(item.addr[12:0]);
                    xl.write_strobe = (item.cmd == CMD_CPU_WRITE);
                end
                else if (item.addr[15] && item.cmd == CMD_CPU_READ)
                begin
                    xl.target   = TGT_PRG_ROM;
                    xl.mem_addr = prg_full[MemAddrW-1:0];
                end
            end
            CMD_CHR_READ,
            CMD_CHR_WRITE:
            begin
                xl.target       = TGT_CHR;
                xl.mem_addr     = MemAddrW'(chr_abs);
                xl.out_of_range = chr_oor;
                xl.write_strobe = (item.cmd == CMD_CHR_WRITE) && cfg.chr_is_ram && !chr_oor;
            end
            default: xl = '0;
        endcase
    end

endmodule

### rtl/core/mmc3_ctrl.sv
`timescale 1ns / 1ps

module mmc3_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  mmc3_pkg::item_t      item,
    output mmc3_pkg::map_state_t state,
    output mmc3_pkg::map_state_t state_next
);
    import mmc3_pkg::*;

    map_state_t state_reg;
    map_state_t st_next;
    logic       a12;
    logic [7:0] count_new;

    assign a12 = item.addr[12];

    always_comb
    begin
        st_next   = state_reg;
        count_new = state_reg.irq_count;
        case (item.cmd)
            CMD_CPU_WRITE:
            begin
                if (item.addr[15])
                begin
                    case (item.addr[14:13])
                        WIN_BANK:
                        begin
                            if (!item.addr[0])
                            begin
                                st_next.bank_select     = item.value[2:0];
                                st_next.prg_swap_mode   = item.value[6];
                                st_next.chr_invert_mode = item.value[7];
                            end
                            else
                            begin
                                st_next.bank_regs[state_reg.bank_select] = item.value;
                            end
                        end
                        WIN_MIRROR:
                        begin
                            if (!item.addr[0])
                                st_next.mirror_state = item.value[0];
                        end
                        WIN_IRQ:
                        begin
                            if (!item.addr[0])
                                st_next.irq_latch = item.value;
                            else
                                st_next.irq_reload_flag = 1'b1;
                        end
                        WIN_IRQ_EN:
                        begin
                            if (!item.addr[0])
                            begin
                                st_next.irq_enabled = 1'b0;
                                st_next.irq_pending = 1'b0;
                            end
                            else
                            begin
                                st_next.irq_enabled = 1'b1;
                            end
                        end
                        default: st_next = state_reg;
                    endcase
                end
            end
            CMD_PPU_WATCH:
            begin
                // Clock the counter on a rising edge of A12
                if (!state_reg.prev_a12 && a12)
                begin
                    if (state_reg.irq_count == '0 || state_reg.irq_reload_flag)
                    begin
                        count_new               = state_reg.irq_latch;
                        st_next.irq_reload_flag = 1'b0;
                    end
                    else
                    begin
                        count_new = state_reg.irq_count - 1'b1;
                    end
                    st_next.irq_count = count_new;
                    if (count_new == '0 && state_reg.irq_enabled)
                        st_next.irq_pending = 1'b1;
                end
                st_next.prev_a12 = a12;
            end
            default: st_next = state_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (step)
            state_reg <= st_next;
    end

    assign state      = state_reg;
    assign state_next = st_next;

endmodule

### rtl/core/mmc3_bank_mapper_irq_core.sv
`timescale 1ns / 1ps

// MMC3-style bank mapper with scanline IRQ counter. Each transfer on the
// input channel is one bus access (CPU read/write, CHR read/write, or a PPU
// address shown to the A12 edge watcher); each produces exactly one result
// transfer carrying the translated PRG ROM, PRG RAM or CHR address, the write
// strobe, the CHR out-of-range flag and the IRQ and mirroring levels as they
// stand after the access. Throughput is one access per clock while the result
// is not stalled: an access is held in the input register, is translated and
// applied to the mapper state in a single pass, and lands in the result
// register, which drives out_valid; a new access can enter the input
// register as the previous one moves on. A stalled result holds the input register;
// once that is full the input channel is stalled too. The
// three configuration registers (PRG bank count, CHR bank count, CHR-is-RAM)
// sit at byte addresses 0, 4 and 8 of the APB port and must only be written
// while no access is in flight.

module mmc3_bank_mapper_irq_core
#(
    parameter int ROM_ADDR_BITS = mmc3_pkg::RomAddrBitsDefault
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mmc3_pkg::item_t               in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mmc3_pkg::result_t             out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mmc3_pkg::CfgAddrW-1:0] paddr,
    input  logic [mmc3_pkg::CfgDataW-1:0] pwdata,
    output logic [mmc3_pkg::CfgDataW-1:0] prdata,
    output logic                          pready
);
    import mmc3_pkg::*;

    cfg_t       cfg;
    map_state_t state;
    map_state_t state_next;
    xlate_t     xl;

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t out_next;

    logic advance;
    logic step;
    logic in_take;

    // Advance when the result register is empty or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    mmc3_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mmc3_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item       (in_reg),
        .state      (state),
        .state_next (state_next)
    );

    mmc3_xlate #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_xlate
    (
        .item  (in_reg),
        .cfg   (cfg),
        .state (state),
        .xl    (xl)
    );

    // Result fields: translation from the pre-access state, lines from the
    // post-access state
    always_comb
    begin
        out_next.target          = xl.target;
        out_next.mem_addr        = xl.mem_addr;
        out_next.write_strobe    = xl.write_strobe;
        out_next.out_of_range    = xl.out_of_range;
        out_next.irq_line        = state_next.irq_pending;
        out_next.mirror_vertical = state_next.mirror_state;
    end

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = step;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_reg <= in_item;
        if (step)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // A strobe always has a memory behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.write_strobe |-> out_item.target != TGT_NONE)
        else $error("write strobe with no target");

    // Out of range only for CHR, and never strobed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_of_range |->
            out_item.target == TGT_CHR && !out_item.write_strobe)
        else $error("out-of-range flag on a non-CHR or strobed result");

    // No target means no address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.target == TGT_NONE |-> out_item.mem_addr == '0)
        else $error("address on a result with no target");

    // IRQ only rises from an applied PPU watch access
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state.irq_pending) |-> $past(step) && $past(in_reg.cmd) == CMD_PPU_WATCH)
        else $error("IRQ raised without an A12 watch access");

endmodule

### sim/tb_mmc3_bank_mapper_irq_core.sv
`timescale 1ns / 1ps

module tb_mmc3_bank_mapper_irq_core;
    import mmc3_pkg::*;

    class mapper_scoreboard;
        localparam int RomBits = RomAddrBitsDefault;

        result_t     expected_results[$];
        int          errors;

        logic [8:0]  prg_count;
        logic [8:0]  chr_count;
        logic        chr_ram;

        logic [7:0]  banks [8];
        logic [2:0]  sel;
        logic        prg_swap;
        logic        chr_invert;
        logic        mirror_v;
        logic [7:0]  irq_latch;
        logic [7:0]  irq_count;
        logic        irq_reload;
        logic        irq_enabled;
        logic        irq_pending;
        logic        prev_a12;

        function new();
            errors      = 0;
            prg_count   = 9'd2;
            chr_count   = 9'd8;
            chr_ram     = 1'b0;
            foreach (banks[i]) banks[i] = 8'd0;
            sel         = 3'd0;
            prg_swap    = 1'b0;
            chr_invert  = 1'b0;
            mirror_v    = 1'b0;
            irq_latch   = 8'd0;
            irq_count   = 8'd0;
            irq_reload  = 1'b0;
            irq_enabled = 1'b0;
            irq_pending = 1'b0;
            prev_a12    = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_PRG_COUNT: prg_count = val[8:0];
                REG_CHR_COUNT: chr_count = val[8:0];
                REG_CHR_RAM:   chr_ram   = val[0];
                default: ;
            endcase
        endfunction

        function bit busy();
            return expected_results.size() != 0;
        endfunction

        function logic [20:0] prg_address(logic [15:0] a);
            logic [8:0]  last;
            logic [8:0]  second;
            logic [8:0]  bank;
            logic [31:0] full;
            last   = (prg_count == 9'd0) ? 9'd0 : prg_count - 9'd1;
            second = (prg_count < 9'd2) ? 9'd0 : prg_count - 9'd2;
            // slot is the 8KB window within $8000-$FFFF
            case (a[14:13])
                2'd1:    bank = {1'b0, banks[7]};
                2'd3:    bank = last;
                default: bank = ((a[14:13] == 2'd0) == !prg_swap) ? {1'b0, banks[6]}
                                                                   : second;
            endcase
            if (bank >= prg_count) bank = last;
            full = ({23'd0, bank} << 13) | {19'd0, a[12:0]};
            full = full & ((32'd1 << RomBits) - 32'd1);
            return full[20:0];
        endfunction

        function logic [31:0] chr_address(logic [15:0] a);
            logic [12:0] p;
            p = a[12:0];
            if (chr_invert) p[12] = ~p[12];
            // 2KB windows take the even bank of the pair
            if (!p[12]) return 32'(banks[p[11]] & 8'hFE) * 32'h400 + 32'(p[10:0]);
            return 32'(banks[2 + p[11:10]]) * 32'h400 + 32'(p[9:0]);
        endfunction

        function void write_mapper(logic [15:0] a, logic [7:0] v);
            case (a[14:13])
                WIN_BANK:
                    if (!a[0])
                    begin
                        sel        = v[2:0];
                        prg_swap   = v[6];
                        chr_invert = v[7];
                    end
                    else
                    begin
                        banks[sel] = v;
                    end
                WIN_MIRROR:
                    if (!a[0]) mirror_v = v[0];
                WIN_IRQ:
                    if (!a[0]) irq_latch = v;
                    else irq_reload = 1'b1;
                WIN_IRQ_EN:
                    if (!a[0])
                    begin
                        irq_enabled = 1'b0;
                        irq_pending = 1'b0;
                    end
                    else
                    begin
                        irq_enabled = 1'b1;
                    end
                default: ;
            endcase
        endfunction

        function void watch_ppu(logic a12);
            if (!prev_a12 && a12)
            begin
                if (irq_count == 8'd0 || irq_reload)
                begin
                    irq_count  = irq_latch;
                    irq_reload = 1'b0;
                end
                else
                begin
                    irq_count = irq_count - 8'd1;
                end
                if (irq_count == 8'd0 && irq_enabled) irq_pending = 1'b1;
            end
            prev_a12 = a12;
        endfunction

        function void note_access(item_t acc);
            result_t     r;
            logic [31:0] chr_abs;
            r = '0;
            case (acc.cmd)
                CMD_CPU_READ, CMD_CPU_WRITE:
                    if (acc.addr >= 16'h6000 && acc.addr < 16'h8000)
                    begin
                        r.target       = TGT_PRG_RAM;
                        r.mem_addr     = 21'(acc.addr - 16'h6000);
                        r.write_strobe = (acc.cmd == CMD_CPU_WRITE);
                    end
                    else if (acc.addr >= 16'h8000)
                    begin
                        if (acc.cmd == CMD_CPU_READ)
                        begin
                            r.target   = TGT_PRG_ROM;
                            r.mem_addr = prg_address(acc.addr);
                        end
                        else
                        begin
                            write_mapper(acc.addr, acc.value);
                        end
                    end
                CMD_CHR_READ, CMD_CHR_WRITE:
                begin
                    chr_abs        = chr_address(acc.addr);
                    r.target       = TGT_CHR;
                    r.mem_addr     = 21'(chr_abs);
                    r.out_of_range = (chr_abs >= 32'(chr_count) * 32'h400);
                    r.write_strobe = (acc.cmd == CMD_CHR_WRITE) && chr_ram
                                     && !r.out_of_range;
                end
                CMD_PPU_WATCH:
                    watch_ppu(acc.addr[12]);
                default: ;
            endcase
            r.irq_line        = irq_pending;
            r.mirror_vertical = mirror_v;
            expected_results.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare("target", 32'(want.target), 32'(got.target));
            compare("mem_addr", 32'(want.mem_addr), 32'(got.mem_addr));
            compare("write_strobe", 32'(want.write_strobe), 32'(got.write_strobe));
            compare("out_of_range", 32'(want.out_of_range), 32'(got.out_of_range));
            compare("irq_line", 32'(want.irq_line), 32'(got.irq_line));
            compare("mirror_vertical", 32'(want.mirror_vertical),
                    32'(got.mirror_vertical));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    item_t               in_item;
    logic                out_valid;
    logic                out_stall = 1'b0;
    result_t             out_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CfgAddrW-1:0] paddr;
    logic [CfgDataW-1:0] pwdata;
    logic [CfgDataW-1:0] prdata;
    logic                pready;

    // in_calm / out_calm switch off idling on either side for a whole phase
    bit                  in_calm  = 1'b0;
    bit                  out_calm = 1'b0;
    int                  stall_hold = 0;

    mapper_scoreboard    sb = new();

    mmc3_bank_mapper_irq_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Idle length: mostly none, often short, now and then a long pause
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic item_t make_access(logic [2:0] c, logic [15:0] a, logic [7:0] v);
        item_t acc;
        acc.cmd   = c;
        acc.addr  = a;
        acc.value = v;
        return acc;
    endfunction

    // Bank numbers: half the time small, so they often land inside the present banks
    function automatic logic [7:0] bank_value();
        if ($urandom_range(0, 1) != 0) return 8'($urandom_range(0, 15));
        return 8'($urandom);
    endfunction

    // Receiver side: hold out_stall high or low for a random stretch, then redraw
    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            stall_hold = stall_hold - 1;
        end
        else if (out_calm)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 2) == 0);
            stall_hold = idle_length();
        end
    end

    // Check every result transfer; values are sampled as they stood at the edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    end

    // Offer one access and hold it until the transfer happens. Valid is only
    // dropped where a gap is wanted, so back-to-back transfers keep it high.
    task automatic send_access(input item_t acc);
        int gap;
        gap = in_calm ? 0 : idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= acc;
        do @(posedge clk); while (in_stall);
        sb.note_access(acc);
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.busy()) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_setting(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic apply_settings(input int prg, input int chr, input int ram);
        write_setting(REG_PRG_COUNT, 32'(prg));
        write_setting(REG_CHR_COUNT, 32'(chr));
        write_setting(REG_CHR_RAM, 32'(ram));
    endtask

    // Directed accesses under the reset settings (2 PRG banks, 8 CHR banks, CHR ROM)
    task automatic run_directed();
        // below $6000 nothing is hit; $6000-$7FFF is PRG RAM
        send_access(make_access(CMD_CPU_READ, 16'h0000, 8'h00));
        send_access(make_access(CMD_CPU_WRITE, 16'h5FFF, 8'hFF));
        send_access(make_access(CMD_CPU_WRITE, 16'h6000, 8'hA5));
        send_access(make_access(CMD_CPU_READ, 16'h7FFF, 8'h00));
        // PRG windows in normal mode: first slot and the fixed last bank
        send_access(make_access(CMD_CPU_READ, 16'h8000, 8'h00));
        send_access(make_access(CMD_CPU_READ, 16'hFFFF, 8'h00));
        // select R6 with PRG swap, load a bank past the end so it clamps
        send_access(make_access(CMD_CPU_WRITE, 16'h8000, 8'h46));
        send_access(make_access(CMD_CPU_WRITE, 16'h8001, 8'hFF));
        send_access(make_access(CMD_CPU_READ, 16'hC000, 8'h00));
        send_access(make_access(CMD_CPU_READ, 16'h8123, 8'h00));
        // CHR invert, R0 odd and high: 2KB window clears the low bit, out of range
        send_access(make_access(CMD_CPU_WRITE, 16'h8000, 8'h80));
        send_access(make_access(CMD_CPU_WRITE, 16'h8001, 8'hFF));
        send_access(make_access(CMD_CHR_READ, 16'h1234, 8'h00));
        send_access(make_access(CMD_CHR_WRITE, 16'h0FFF, 8'h5A));
        send_access(make_access(CMD_CHR_READ, 16'hFFFF, 8'h00));
        // mirroring to vertical, then an IRQ counter run that fires
        send_access(make_access(CMD_CPU_WRITE, 16'hA000, 8'h01));
        send_access(make_access(CMD_CPU_WRITE, 16'hC000, 8'h02));
        send_access(make_access(CMD_CPU_WRITE, 16'hC001, 8'h00));
        send_access(make_access(CMD_CPU_WRITE, 16'hE001, 8'h00));
        send_access(make_access(CMD_PPU_WATCH, 16'h1000, 8'h00));
        send_access(make_access(CMD_PPU_WATCH, 16'h0000, 8'h00));
        send_access(make_access(CMD_PPU_WATCH, 16'h1000, 8'h00));
        send_access(make_access(CMD_PPU_WATCH, 16'hEFFF, 8'h00));
        send_access(make_access(CMD_PPU_WATCH, 16'hFFFF, 8'h00));
        // IRQ disable clears the pending line
        send_access(make_access(CMD_CPU_WRITE, 16'hE000, 8'h00));
        // unused commands leave everything alone
        send_access(make_access(3'd5, 16'hFFFF, 8'hFF));
        send_access(make_access(3'd6, 16'h8001, 8'h00));
        send_access(make_access(3'd7, 16'h6000, 8'h11));
    endtask

    // Random traffic, mostly well-formed register sequences and bus accesses
    task automatic run_traffic(input int count);
        int          sent;
        int          kind;
        int          k;
        bit          level;
        logic [15:0] a;
        sent  = 0;
        level = 1'b0;
        while (sent < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 20)
            begin
                // bank select then bank data
                send_access(make_access(CMD_CPU_WRITE, {1'b1, WIN_BANK, 12'($urandom), 1'b0},
                                        8'($urandom)));
                send_access(make_access(CMD_CPU_WRITE, {1'b1, WIN_BANK, 12'($urandom), 1'b1},
                                        bank_value()));
                sent += 2;
            end
            else if (kind < 35)
            begin
                // latch, reload, enable (sometimes disable), then a run of PPU watch accesses with A12 toggling
                send_access(make_access(CMD_CPU_WRITE, {1'b1, WIN_IRQ, 12'($urandom), 1'b0},
                                        8'($urandom_range(0, 4))));
                send_access(make_access(CMD_CPU_WRITE, {1'b1, WIN_IRQ, 12'($urandom), 1'b1},
                                        8'($urandom)));
                send_access(make_access(CMD_CPU_WRITE,
                                        {1'b1, WIN_IRQ_EN, 12'($urandom),
                                         ($urandom_range(0, 4) != 0)},
                                        8'($urandom)));
                k = $urandom_range(4, 16);
                repeat (k)
                begin
                    if ($urandom_range(0, 3) != 0) level = !level;
                    a     = 16'($urandom);
                    a[12] = level;
                    send_access(make_access(CMD_PPU_WATCH, a, 8'($urandom)));
                end
                sent += 3 + k;
            end
            else if (kind < 55)
            begin
                send_access(make_access(CMD_CPU_READ, 16'($urandom) | 16'h8000,
                                        8'($urandom)));
                sent++;
            end
            else if (kind < 75)
            begin
                send_access(make_access(($urandom_range(0, 1) != 0) ? CMD_CHR_WRITE
                                                                    : CMD_CHR_READ,
                                        16'($urandom), 8'($urandom)));
                sent++;
            end
            else if (kind < 83)
            begin
                send_access(make_access(($urandom_range(0, 1) != 0) ? CMD_CPU_WRITE
                                                                    : CMD_CPU_READ,
                                        {3'b011, 13'($urandom)}, 8'($urandom)));
                sent++;
            end
            else if (kind < 88)
            begin
                send_access(make_access(CMD_CPU_WRITE, 16'($urandom) | 16'h8000,
                                        8'($urandom)));
                sent++;
            end
            else
            begin
                // noise: any command, any address, any data
                send_access(make_access(3'($urandom), 16'($urandom), 8'($urandom)));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        settle();

        // Each phase: new settings while idle, then random traffic
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: apply_settings(2, 0, 1);
                1: apply_settings(256, 256, 1);
                2: apply_settings(0, 1, 0);
                3: apply_settings(1, 64, 1);
                4: apply_settings(511, 511, 0);
                5: apply_settings($urandom_range(2, 256), $urandom_range(0, 256),
                                  $urandom_range(0, 1));
                default: apply_settings(32, 8, 1);
            endcase
            in_calm  = (ph == 1 || ph == 6);
            out_calm <= (ph == 2 || ph == 6);
            run_traffic(75);
            settle();
        end

        // let any stray result surface before the verdict
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Run limit, several times the slowest legal run
    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
